// ----- sv/sha1md_pkg.sv -----
// Package with the shared types and constants of the SHA-1 message digest block.
`default_nettype none
package sha1md_pkg;

  localparam logic [0:4][31:0] SHA1_IV = {
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_PR2 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int unsigned ROUNDS = 80;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_w0;
    logic [31:0] digest_w1;
    logic [31:0] digest_w2;
    logic [31:0] digest_w3;
    logic [31:0] digest_w4;
  } sha1_out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } wv_t;

endpackage
`default_nettype wire

// ----- sv/sha1md_round.sv -----
// One SHA-1 round with the schedule word expansion from the memory read data.
`default_nettype none
module sha1md_round import sha1md_pkg::*; (
  input  wv_t         wv_in,
  input  logic [6:0]  idx,
  input  logic [31:0] x1,
  input  logic [31:0] rd0,
  input  logic [31:0] rd1,
  output logic [31:0] w,
  output wv_t         wv_out
);

  logic [31:0] x_all;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] a_rot;

  assign x_all = x1 ^ rd0 ^ rd1;
  assign w     = (idx >= 7'd16) ? {x_all[30:0], x_all[31]} : rd1;
  assign a_rot = {wv_in.a[26:0], wv_in.a[31:27]};

  always_comb begin
    if (idx < 7'd20) begin
      f = (wv_in.b & wv_in.c) | (~wv_in.b & wv_in.d);
      k = K_CH;
    end else if (idx < 7'd40) begin
      f = wv_in.b ^ wv_in.c ^ wv_in.d;
      k = K_PAR;
    end else if (idx < 7'd60) begin
      f = (wv_in.b & wv_in.c) | (wv_in.b & wv_in.d) | (wv_in.c & wv_in.d);
      k = K_MAJ;
    end else begin
      f = wv_in.b ^ wv_in.c ^ wv_in.d;
      k = K_PR2;
    end
  end

  always_comb begin
    wv_out.a = a_rot + f + wv_in.e + k + w;
    wv_out.b = wv_in.a;
    wv_out.c = {wv_in.b[1:0], wv_in.b[31:2]};
    wv_out.d = wv_in.c;
    wv_out.e = wv_in.d;
  end

endmodule
`default_nettype wire

// ----- sv/sha1_message_digest_top.sv -----
// Top level of the SHA-1 message digest block: byte packing, padding and round sequencer.
// A byte request is taken while idle; a byte that completes a block starts a compression.
// Each round is split in phases, as four schedule words are read through two memory read ports.
// An end request writes the pad word, then the zero fill and length words, and adds one or two compressions.
// The digest waits in an output register while the next message is taken in.
// Synchronous active-low reset restores the initial chain value and clears the byte count.
`default_nettype none
module sha1_message_digest_top import sha1md_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sha1_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output sha1_out_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RND  = 5'b00010,
    S_FIN  = 5'b00100,
    S_PAD  = 5'b01000,
    S_FILL = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [0:4][31:0] chain_r, chain_nxt;
  wv_t              wv_r, wv_nxt;
  logic [60:0]      cnt_r, cnt_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [6:0]       k_r, k_nxt;
  logic             ph_r, ph_nxt;
  logic [31:0]      x1_r, x1_nxt;
  logic [3:0]       wp_r, wp_nxt;
  logic             lenblk_r, lenblk_nxt;
  logic             end_pend_r, end_pend_nxt;
  logic             pad_done_r, pad_done_nxt;
  logic             final_r, final_nxt;
  logic             out_valid_r, out_valid_nxt;
  sha1_out_t        out_r, out_nxt;

  logic [31:0] mem [16];
  logic [31:0] rd0_r, rd1_r;
  logic        mem_we;
  logic [3:0]  mem_wa;
  logic [31:0] mem_wd;
  logic [3:0]  ra0, ra1;

  logic             acc_in;
  logic [5:0]       pos;
  logic [6:0]       kp;
  logic [31:0]      w;
  wv_t              wv_rnd;
  logic [0:4][31:0] sum;
  logic [31:0]      pad_word;
  logic             out_free;

  sha1md_round u_round (
    .wv_in  (wv_r),
    .idx    (kp),
    .x1     (x1_r),
    .rd0    (rd0_r),
    .rd1    (rd1_r),
    .w      (w),
    .wv_out (wv_rnd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign acc_in    = in_valid && (state_r == S_IDLE);
  assign pos       = cnt_r[5:0];
  assign kp        = k_r - 7'd1;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    if (ph_r) begin
      ra0 = k_r[3:0] + 4'd2;
      ra1 = k_r[3:0];
    end else begin
      ra0 = k_r[3:0] + 4'd13;
      ra1 = k_r[3:0] + 4'd8;
    end
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      sum[i] = chain_r[i] + wv_r[(4 - i) * 32 +: 32];
    end
  end

  always_comb begin
    case (pos[1:0])
      2'd0:    pad_word = {PAD_BYTE, 24'd0};
      2'd1:    pad_word = {acc_r[31:24], PAD_BYTE, 16'd0};
      2'd2:    pad_word = {acc_r[31:16], PAD_BYTE, 8'd0};
      default: pad_word = {acc_r[31:8], PAD_BYTE};
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    chain_nxt     = chain_r;
    wv_nxt        = wv_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    ph_nxt        = ph_r;
    x1_nxt        = x1_r;
    wp_nxt        = wp_r;
    lenblk_nxt    = lenblk_r;
    end_pend_nxt  = end_pend_r;
    pad_done_nxt  = pad_done_r;
    final_nxt     = final_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_wa        = 4'd0;
    mem_wd        = 32'd0;

    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          if (in_data.has_byte) begin
            case (pos[1:0])
              2'd0:    acc_nxt[31:24] = in_data.msg_byte;
              2'd1:    acc_nxt[23:16] = in_data.msg_byte;
              2'd2:    acc_nxt[15:8]  = in_data.msg_byte;
              default: acc_nxt[7:0]   = in_data.msg_byte;
            endcase
            if (pos[1:0] == 2'd3) begin
              mem_we = 1'b1;
              mem_wa = pos[5:2];
              mem_wd = {acc_r[31:8], in_data.msg_byte};
            end
            cnt_nxt = cnt_r + 61'd1;
            if (pos == 6'd63) begin
              state_nxt    = S_RND;
              k_nxt        = 7'd0;
              ph_nxt       = 1'b0;
              wv_nxt       = {chain_r[0], chain_r[1], chain_r[2], chain_r[3], chain_r[4]};
              final_nxt    = 1'b0;
              end_pend_nxt = in_data.end_of_message;
            end else if (in_data.end_of_message) begin
              state_nxt    = S_PAD;
              end_pend_nxt = 1'b1;
            end
          end else if (in_data.end_of_message) begin
            state_nxt    = S_PAD;
            end_pend_nxt = 1'b1;
          end
        end
      end
      S_PAD: begin
        mem_we     = 1'b1;
        mem_wa     = pos[5:2];
        mem_wd     = pad_word;
        lenblk_nxt = (pos < 6'd56);
        if (pos[5:2] == 4'd15) begin
          state_nxt    = S_RND;
          k_nxt        = 7'd0;
          ph_nxt       = 1'b0;
          wv_nxt       = {chain_r[0], chain_r[1], chain_r[2], chain_r[3], chain_r[4]};
          final_nxt    = 1'b0;
          pad_done_nxt = 1'b1;
        end else begin
          state_nxt = S_FILL;
          wp_nxt    = pos[5:2] + 4'd1;
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        mem_wa = wp_r;
        if (lenblk_r && (wp_r == 4'd14)) begin
          mem_wd = cnt_r[60:29];
        end else if (lenblk_r && (wp_r == 4'd15)) begin
          mem_wd = {cnt_r[28:0], 3'd0};
        end else begin
          mem_wd = 32'd0;
        end
        if (wp_r == 4'd15) begin
          state_nxt    = S_RND;
          k_nxt        = 7'd0;
          ph_nxt       = 1'b0;
          wv_nxt       = {chain_r[0], chain_r[1], chain_r[2], chain_r[3], chain_r[4]};
          final_nxt    = lenblk_r;
          pad_done_nxt = 1'b1;
        end else begin
          wp_nxt = wp_r + 4'd1;
        end
      end
      S_RND: begin
        if (!ph_r) begin
          if (k_r != 7'd0) begin
            wv_nxt = wv_rnd;
            if (kp >= 7'd16) begin
              mem_we = 1'b1;
              mem_wa = kp[3:0];
              mem_wd = w;
            end
          end
          if (k_r == 7'(ROUNDS)) begin
            state_nxt = S_FIN;
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          x1_nxt = rd0_r ^ rd1_r;
          ph_nxt = 1'b0;
          k_nxt  = k_r + 7'd1;
        end
      end
      S_FIN: begin
        if (final_r) begin
          if (out_free) begin
            out_nxt       = {sum[0], sum[1], sum[2], sum[3], sum[4]};
            out_valid_nxt = 1'b1;
            chain_nxt     = SHA1_IV;
            cnt_nxt       = 61'd0;
            end_pend_nxt  = 1'b0;
            pad_done_nxt  = 1'b0;
            final_nxt     = 1'b0;
            state_nxt     = S_IDLE;
          end
        end else begin
          chain_nxt = sum;
          if (end_pend_r) begin
            if (pad_done_r) begin
              state_nxt  = S_FILL;
              wp_nxt     = 4'd0;
              lenblk_nxt = 1'b1;
            end else begin
              state_nxt = S_PAD;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chain_r     <= SHA1_IV;
      cnt_r       <= 61'd0;
      k_r         <= 7'd0;
      ph_r        <= 1'b0;
      wp_r        <= 4'd0;
      lenblk_r    <= 1'b0;
      end_pend_r  <= 1'b0;
      pad_done_r  <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      ph_r        <= ph_nxt;
      wp_r        <= wp_nxt;
      lenblk_r    <= lenblk_nxt;
      end_pend_r  <= end_pend_nxt;
      pad_done_r  <= pad_done_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wv_r  <= wv_nxt;
    acc_r <= acc_nxt;
    x1_r  <= x1_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

`ifndef SYNTHESIS
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND) |-> (k_r <= 7'(ROUNDS)))
    else $error("Round counter ran past the last round.");

  a_phase_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r |-> (state_r == S_RND))
    else $error("Second read phase seen outside the round sequence.");

  a_digest_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past((state_r == S_FIN) && final_r))
    else $error("Digest shown without a finished final block.");

  a_pad_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PAD) || (state_r == S_FILL)) |-> end_pend_r)
    else $error("Padding runs without an end request.");
`endif

endmodule
`default_nettype wire

// ----- tb/sha1_message_digest_top_tb.sv -----
// Self-checking testbench for the SHA-1 message digest block with a built-in digest predictor.
module sha1_message_digest_top_tb import sha1md_pkg::*;;

  localparam int HOLD_CYCLES  = 1500;
  localparam int STALL_LIMIT  = 8000;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  sha1_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sha1_out_t out_data;

  logic [31:0] chain_val [5];
  logic [31:0] blk_words [16];
  logic [60:0] msg_len;
  sha1_out_t   pending_digests [$];
  string       field_names [5] = '{"digest_w0", "digest_w1", "digest_w2", "digest_w3",
                                   "digest_w4"};

  int fail_count    = 0;
  int requests_sent = 0;
  int idle_cycles   = 0;
  int hold_left     = 0;
  int rx_wait       = 0;
  int rx_burst      = 0;
  bit tx_idle_en    = 1'b1;
  bit hold_req      = 1'b0;

  sha1_message_digest_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void put_byte(int pos, logic [7:0] v);
    blk_words[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = v;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    int s;
    w = blk_words;
    a = chain_val[0];
    b = chain_val[1];
    c = chain_val[2];
    d = chain_val[3];
    e = chain_val[4];
    for (int r = 0; r < ROUNDS; r++) begin
      s = r & 15;
      if (r >= 16) begin
        w[s] = rol(w[(s + 13) & 15] ^ w[(s + 8) & 15] ^ w[(s + 2) & 15] ^ w[s], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_PAR;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_PR2;
      end
      t = rol(a, 5) + f + e + k + w[s];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_val[0] += a;
    chain_val[1] += b;
    chain_val[2] += c;
    chain_val[3] += d;
    chain_val[4] += e;
  endfunction

  function automatic void restart_chain();
    foreach (chain_val[i]) chain_val[i] = SHA1_IV[i];
    msg_len = '0;
  endfunction

  function automatic void predict_digest(sha1_in_t req);
    int pos;
    logic [63:0] bit_len;
    if (req.has_byte) begin
      pos = int'(msg_len[5:0]);
      put_byte(pos, req.msg_byte);
      msg_len = msg_len + 61'd1;
      if (pos == 63) compress_block();
    end
    if (req.end_of_message) begin
      pos = int'(msg_len[5:0]);
      put_byte(pos, PAD_BYTE);
      for (int p = pos + 1; p < 64; p++) put_byte(p, 8'h00);
      if (pos >= 56) begin
        compress_block();
        foreach (blk_words[i]) blk_words[i] = '0;
      end
      bit_len = {msg_len, 3'b000};
      blk_words[14] = bit_len[63:32];
      blk_words[15] = bit_len[31:0];
      compress_block();
      pending_digests.push_back({chain_val[0], chain_val[1], chain_val[2], chain_val[3],
                                 chain_val[4]});
      restart_chain();
    end
  endfunction

  function automatic sha1_in_t make_request(logic [7:0] b, logic has, logic eom);
    sha1_in_t req;
    req.msg_byte       = b;
    req.has_byte       = has;
    req.end_of_message = eom;
    return req;
  endfunction

  always @(posedge clk) begin
    sha1_out_t want;
    logic [0:4][31:0] want_w;
    logic [0:4][31:0] got_w;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_digest(in_data);
      if (out_valid && !out_stall) begin
        if (rx_burst > 0) begin
          rx_burst--;
          rx_wait = 0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_burst = $urandom_range(2, 6);
          rx_wait = 0;
        end else begin
          rx_wait = $urandom_range(0, 18);
        end
        if (pending_digests.size() == 0) begin
          $error("digest %h arrived with no message pending", out_data);
          fail_count++;
        end else begin
          want = pending_digests.pop_front();
          want_w = want;
          got_w = out_data;
          for (int i = 0; i < 5; i++) begin
            if (got_w[i] !== want_w[i]) begin
              $error("%s expected %h actual %h", field_names[i], want_w[i], got_w[i]);
              fail_count++;
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("sha1_message_digest_top verification failed");
      $finish;
    end
  end

  task automatic send_request(input sha1_in_t req);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req.has_byte || req.end_of_message) requests_sent++;
  endtask

  task automatic send_message(input int n_bytes, input bit end_on_byte);
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_request(make_request(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      end
      send_request(make_request(8'($urandom_range(0, 255)), 1'b1,
                                end_on_byte && (i == n_bytes - 1)));
    end
    if (!end_on_byte || n_bytes == 0) begin
      send_request(make_request(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    end
  endtask

  task automatic test_empty_message();
    send_request(make_request(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  task automatic test_abc_message();
    send_request(make_request(8'h61, 1'b1, 1'b0));
    send_request(make_request(8'h62, 1'b1, 1'b0));
    send_request(make_request(8'h63, 1'b1, 1'b1));
  endtask

  task automatic test_byte_extremes();
    send_request(make_request(8'h00, 1'b1, 1'b0));
    send_request(make_request(8'hFF, 1'b0, 1'b0));
    send_request(make_request(8'hFF, 1'b1, 1'b0));
    send_request(make_request(8'h00, 1'b0, 1'b0));
    send_request(make_request(8'h5A, 1'b1, 1'b0));
    send_request(make_request(8'hA5, 1'b0, 1'b1));
    send_request(make_request(8'h80, 1'b1, 1'b1));
  endtask

  task automatic test_output_hold();
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    repeat (6) send_message($urandom_range(0, 4), 1'($urandom_range(0, 1)));
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_messages();
    int start;
    int n;
    start = requests_sent;
    while (requests_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: n = $urandom_range(0, 15);
        5, 6, 7, 8:    n = 64 * $urandom_range(0, 1) + 54 + $urandom_range(0, 11);
        default:       n = $urandom_range(0, 140);
      endcase
      tx_idle_en = ($urandom_range(0, 3) != 0);
      send_message(n, 1'($urandom_range(0, 1)));
    end
    tx_idle_en = 1'b1;
  endtask

  initial begin
    restart_chain();
    foreach (blk_words[i]) blk_words[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_message();
    test_abc_message();
    test_byte_extremes();
    test_output_hold();
    test_random_messages();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("sha1_message_digest_top verification clean");
    end else begin
      $display("sha1_message_digest_top verification failed");
    end
    $finish;
  end

endmodule

// ----- sha1_message_digest_top.f -----
sv/sha1md_pkg.sv
sv/sha1md_round.sv
sv/sha1_message_digest_top.sv
tb/sha1_message_digest_top_tb.sv
